/* design/typed_nearest_point_registry_top_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the typed nearest point registry
// Concurrent checks that compile away in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef TYPED_NEAREST_POINT_REGISTRY_TOP_MACROS_SVH
`define TYPED_NEAREST_POINT_REGISTRY_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset
`define TNPR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("registry assertion failed");

// Next-cycle implication, disabled during reset
`define TNPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("registry assertion failed");

`else

`define TNPR_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define TNPR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* design/tnpr_pkg.sv */
// ---------------------------------------------------------------------------
// tnpr_pkg
// Shared types and constants of the typed nearest point registry.
// ---------------------------------------------------------------------------
package tnpr_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int COORD_W     = 24;
    localparam int ID_W        = 16;
    localparam int KIND_W      = 4;
    localparam int SQ_W        = 2 * COORD_W;
    localparam int DIST_W      = 50;

    typedef enum logic [1:0] {
        OP_REGISTER   = 2'd0,
        OP_UNREGISTER = 2'd1,
        OP_QUERY      = 2'd2,
        OP_UNUSED     = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_KIND_NONE = 2'd1,
        STS_FULL      = 2'd2,
        STS_NO_MATCH  = 2'd3
    } status_t;

    localparam logic [KIND_W-1:0] KIND_NONE = '0;

    typedef struct packed {
        logic [1:0]                opcode;
        logic [ID_W-1:0]           item_id;
        logic [KIND_W-1:0]         item_kind;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ID_W-1:0]   nearest_id;
        logic [DIST_W-1:0] nearest_dist_sq;
    } rsp_t;

    // One table entry as stored in the slot RAM
    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic [ID_W-1:0]           id;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

endpackage

/* design/tnpr_ram.sv */
// ---------------------------------------------------------------------------
// tnpr_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module tnpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/typed_nearest_point_registry_top.sv */
// ---------------------------------------------------------------------------
// typed_nearest_point_registry_top
// Table of typed 3D points with register, unregister and nearest query.
// ---------------------------------------------------------------------------
// The block keeps MAX_ENTRIES slots in one RAM (kind, id, x, y, z) plus a
// flip-flop valid bit per slot that reset clears, so the table is empty right
// after reset with no clearing pass. One item is worked at a time. A register
// item walks the valid bits from slot 0 and writes the first free slot, or
// reports full when the last slot is reached with none free. Unregister and
// query items read every slot through the single RAM read port, one slot per
// cycle. For a query, the RAM read, a difference stage, a square stage, a sum
// stage and the compare against the best candidate follow the last read.
// Items with kind none and the unused opcode skip the scan. The result
// sits in an output register, so a waiting result does not block acceptance
// of the next item. Query ties go to the lowest slot.
// ---------------------------------------------------------------------------
`include "typed_nearest_point_registry_top_macros.svh"

module typed_nearest_point_registry_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  tnpr_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output tnpr_pkg::rsp_t  rsp
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    // Control state
    state_t                               state_reg, state_next;
    logic [tnpr_pkg::IDX_W-1:0]           idx_reg, idx_next;
    logic [tnpr_pkg::MAX_ENTRIES-1:0]     valid_reg, valid_next;
    logic                                 found_reg, found_next;
    logic                                 rsp_valid_reg, rsp_valid_next;

    // Current item
    tnpr_pkg::opcode_t                    op_reg, op_next;
    tnpr_pkg::status_t                    status_reg, status_next;
    logic [tnpr_pkg::ID_W-1:0]            id_reg, id_next;
    logic [tnpr_pkg::KIND_W-1:0]          kind_reg, kind_next;
    logic signed [tnpr_pkg::COORD_W-1:0]  px_reg, px_next;
    logic signed [tnpr_pkg::COORD_W-1:0]  py_reg, py_next;
    logic signed [tnpr_pkg::COORD_W-1:0]  pz_reg, pz_next;

    // Scan pipeline: read, difference, square, sum
    logic                                 rd_vld_reg, rd_vld_next;
    logic [tnpr_pkg::IDX_W-1:0]           rd_idx_reg;
    logic                                 a_vld_reg, a_vld_next;
    logic [tnpr_pkg::ID_W-1:0]            a_id_reg;
    logic [tnpr_pkg::COORD_W-1:0]         a_dx_reg, a_dy_reg, a_dz_reg;
    logic                                 b_vld_reg;
    logic [tnpr_pkg::ID_W-1:0]            b_id_reg;
    logic [tnpr_pkg::SQ_W-1:0]            b_sx_reg, b_sy_reg, b_sz_reg;
    logic                                 c_vld_reg;
    logic [tnpr_pkg::ID_W-1:0]            c_id_reg;
    logic [tnpr_pkg::DIST_W-1:0]          c_sum_reg;

    // Best candidate
    logic [tnpr_pkg::ID_W-1:0]            best_id_reg, best_id_next;
    logic [tnpr_pkg::DIST_W-1:0]          best_dist_reg, best_dist_next;
    logic                                 best_take;

    tnpr_pkg::rsp_t                       rsp_reg, rsp_next;

    // RAM port
    logic                                 ram_we;
    tnpr_pkg::slot_t                      ram_wdata;
    tnpr_pkg::slot_t                      ram_rdata;
    logic [tnpr_pkg::SLOT_W-1:0]          ram_rdata_raw;

    logic                                 accept;
    logic                                 last_idx;
    logic                                 pipe_busy;
    logic                                 rd_hit;
    logic                                 rsp_load_ok;
    logic signed [tnpr_pkg::COORD_W:0]    dx_s, dy_s, dz_s;
    logic [tnpr_pkg::COORD_W-1:0]         dx_abs, dy_abs, dz_abs;

    tnpr_ram #(
        .WIDTH (tnpr_pkg::SLOT_W),
        .DEPTH (tnpr_pkg::MAX_ENTRIES)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata_raw)
    );

    assign ram_rdata = tnpr_pkg::slot_t'(ram_rdata_raw);

    assign req_stall   = (state_reg != ST_IDLE);
    assign accept      = req_valid && !req_stall;
    assign last_idx    = (idx_reg == tnpr_pkg::IDX_W'(tnpr_pkg::MAX_ENTRIES - 1));
    assign pipe_busy   = rd_vld_reg || a_vld_reg || b_vld_reg || c_vld_reg;
    assign rsp_load_ok = !rsp_valid_reg || !rsp_stall;

    assign ram_wdata.kind = kind_reg;
    assign ram_wdata.id   = id_reg;
    assign ram_wdata.x    = px_reg;
    assign ram_wdata.y    = py_reg;
    assign ram_wdata.z    = pz_reg;

    // Slot read back: valid and of the requested kind
    assign rd_hit = rd_vld_reg && valid_reg[rd_idx_reg]
                    && (ram_rdata.kind == kind_reg);

    // Absolute coordinate differences (25-bit signed, magnitude fits 24 bits)
    always_comb
    begin
        dx_s   = {ram_rdata.x[tnpr_pkg::COORD_W-1], ram_rdata.x}
                 - {px_reg[tnpr_pkg::COORD_W-1], px_reg};
        dy_s   = {ram_rdata.y[tnpr_pkg::COORD_W-1], ram_rdata.y}
                 - {py_reg[tnpr_pkg::COORD_W-1], py_reg};
        dz_s   = {ram_rdata.z[tnpr_pkg::COORD_W-1], ram_rdata.z}
                 - {pz_reg[tnpr_pkg::COORD_W-1], pz_reg};
        dx_abs = dx_s[tnpr_pkg::COORD_W] ? tnpr_pkg::COORD_W'(-dx_s)
                                         : dx_s[tnpr_pkg::COORD_W-1:0];
        dy_abs = dy_s[tnpr_pkg::COORD_W] ? tnpr_pkg::COORD_W'(-dy_s)
                                         : dy_s[tnpr_pkg::COORD_W-1:0];
        dz_abs = dz_s[tnpr_pkg::COORD_W] ? tnpr_pkg::COORD_W'(-dz_s)
                                         : dz_s[tnpr_pkg::COORD_W-1:0];
    end

    // Take the arriving distance when it is the first match or strictly closer
    assign best_take = c_vld_reg && (!found_reg || c_sum_reg < best_dist_reg);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        valid_next     = valid_reg;
        found_next     = found_reg;
        op_next        = op_reg;
        status_next    = status_reg;
        id_next        = id_reg;
        kind_next      = kind_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        pz_next        = pz_reg;
        rd_vld_next    = 1'b0;
        ram_we         = 1'b0;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next     = tnpr_pkg::opcode_t'(req.opcode);
                    id_next     = req.item_id;
                    kind_next   = req.item_kind;
                    px_next     = req.pos_x;
                    py_next     = req.pos_y;
                    pz_next     = req.pos_z;
                    idx_next    = '0;
                    found_next  = 1'b0;
                    status_next = tnpr_pkg::STS_OK;
                    if (tnpr_pkg::opcode_t'(req.opcode) == tnpr_pkg::OP_UNUSED)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (req.item_kind == tnpr_pkg::KIND_NONE)
                    begin
                        status_next = tnpr_pkg::STS_KIND_NONE;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (op_reg == tnpr_pkg::OP_REGISTER)
                begin
                    // Claim the lowest free slot
                    if (!valid_reg[idx_reg])
                    begin
                        ram_we              = 1'b1;
                        valid_next[idx_reg] = 1'b1;
                        state_next          = ST_DONE;
                    end
                    else if (last_idx)
                    begin
                        status_next = tnpr_pkg::STS_FULL;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    // Issue one slot read per cycle
                    rd_vld_next = 1'b1;
                    if (last_idx)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            ST_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                // Hold the result until the output register frees up
                if (rsp_load_ok)
                begin
                    rsp_valid_next           = 1'b1;
                    rsp_next.status          = status_reg;
                    rsp_next.nearest_id      = '0;
                    rsp_next.nearest_dist_sq = '0;
                    if (op_reg == tnpr_pkg::OP_QUERY && status_reg == tnpr_pkg::STS_OK)
                    begin
                        if (found_reg)
                        begin
                            rsp_next.nearest_id      = best_id_reg;
                            rsp_next.nearest_dist_sq = best_dist_reg;
                        end
                        else
                        begin
                            rsp_next.status = tnpr_pkg::STS_NO_MATCH;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Drop every slot that matches on unregister
        if (rd_hit && op_reg == tnpr_pkg::OP_UNREGISTER && ram_rdata.id == id_reg)
        begin
            valid_next[rd_idx_reg] = 1'b0;
        end

        // Mark the query as matched once the first candidate lands
        if (best_take)
        begin
            found_next = 1'b1;
        end
    end

    assign a_vld_next = rd_hit && (op_reg == tnpr_pkg::OP_QUERY);

    // Best-candidate update; strict less-than keeps the lowest slot on ties
    always_comb
    begin
        best_id_next   = best_id_reg;
        best_dist_next = best_dist_reg;
        if (best_take)
        begin
            best_id_next   = c_id_reg;
            best_dist_next = c_sum_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            valid_reg     <= '0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rd_vld_reg    <= 1'b0;
            a_vld_reg     <= 1'b0;
            b_vld_reg     <= 1'b0;
            c_vld_reg     <= 1'b0;
            op_reg        <= tnpr_pkg::OP_UNUSED;
            status_reg    <= tnpr_pkg::STS_OK;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            valid_reg     <= valid_next;
            found_reg     <= found_next;
            rsp_valid_reg <= rsp_valid_next;
            rd_vld_reg    <= rd_vld_next;
            a_vld_reg     <= a_vld_next;
            b_vld_reg     <= a_vld_reg;
            c_vld_reg     <= b_vld_reg;
            op_reg        <= op_next;
            status_reg    <= status_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        id_reg        <= id_next;
        kind_reg      <= kind_next;
        px_reg        <= px_next;
        py_reg        <= py_next;
        pz_reg        <= pz_next;
        rd_idx_reg    <= idx_reg;
        a_id_reg      <= ram_rdata.id;
        a_dx_reg      <= dx_abs;
        a_dy_reg      <= dy_abs;
        a_dz_reg      <= dz_abs;
        b_id_reg      <= a_id_reg;
        b_sx_reg      <= a_dx_reg * a_dx_reg;
        b_sy_reg      <= a_dy_reg * a_dy_reg;
        b_sz_reg      <= a_dz_reg * a_dz_reg;
        c_id_reg      <= b_id_reg;
        c_sum_reg     <= tnpr_pkg::DIST_W'(b_sx_reg) + tnpr_pkg::DIST_W'(b_sy_reg)
                         + tnpr_pkg::DIST_W'(b_sz_reg);
        best_id_reg   <= best_id_next;
        best_dist_reg <= best_dist_next;
        rsp_reg       <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Checks
    `TNPR_ASSERT_NOW(a_idle_pipe_empty, clk, rst_n, state_reg == ST_IDLE, !pipe_busy)
    `TNPR_ASSERT_NOW(a_write_free_slot, clk, rst_n, ram_we,
                     (state_reg == ST_SCAN) && (op_reg == tnpr_pkg::OP_REGISTER)
                     && !valid_reg[idx_reg])
    `TNPR_ASSERT_NEXT(a_fill_step, clk, rst_n, 1'b1,
                      $countones(valid_reg) <= $countones($past(valid_reg)) + 1)
    `TNPR_ASSERT_NOW(a_pipe_only_query, clk, rst_n, a_vld_reg || b_vld_reg || c_vld_reg,
                     op_reg == tnpr_pkg::OP_QUERY)

endmodule

/* sim/typed_nearest_point_registry_top_tb.sv */
// ---------------------------------------------------------------------------
// typed_nearest_point_registry_top_tb
// Self-checking bench: a table of directed items, then random register, unregister,
// query and unused-opcode traffic. Every accepted item is run through a local
// copy of the slot table, and each result is compared field by field in order.
// ---------------------------------------------------------------------------
module typed_nearest_point_registry_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1450;
    localparam int STEADY_FIRST = 600;   // random items in this window see no idling
    localparam int STEADY_LAST  = 900;
    localparam int DRAIN_CYCLES = tnpr_pkg::MAX_ENTRIES + 8;

    localparam logic signed [tnpr_pkg::COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
    localparam logic signed [tnpr_pkg::COORD_W-1:0] COORD_MIN = 24'sh800000;

    // Traffic mixes of the random part: fill the table, churn it, empty it
    typedef enum int {MIX_FILL, MIX_CHURN, MIX_DRAIN} traffic_mix_t;

    typedef struct {
        tnpr_pkg::req_t stim;
        bit             pinned;       // result is typed in below rather than predicted
        tnpr_pkg::rsp_t pinned_rsp;
    } stim_row_t;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_stall;
    tnpr_pkg::req_t req       = '0;
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;
    tnpr_pkg::rsp_t rsp;

    // Local copy of the slot table
    bit                          table_live [tnpr_pkg::MAX_ENTRIES];
    logic [tnpr_pkg::KIND_W-1:0] table_kind [tnpr_pkg::MAX_ENTRIES];
    logic [tnpr_pkg::ID_W-1:0]   table_id   [tnpr_pkg::MAX_ENTRIES];
    longint                      table_x    [tnpr_pkg::MAX_ENTRIES];
    longint                      table_y    [tnpr_pkg::MAX_ENTRIES];
    longint                      table_z    [tnpr_pkg::MAX_ENTRIES];

    tnpr_pkg::rsp_t expected_results [$];
    stim_row_t      directed_rows [25];
    int             fail_count  = 0;
    bit             steady_flow = 1'b0;

    typed_nearest_point_registry_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // Run one item through the local table and return the result it must give
    function automatic tnpr_pkg::rsp_t registry_predict(input tnpr_pkg::req_t r);
        tnpr_pkg::rsp_t res;
        int             free_idx;
        bit             found;
        longint         qx, qy, qz, dx, dy, dz, dist_sq, best;
        res      = '0;
        free_idx = -1;
        found    = 1'b0;
        best     = 0;
        qx = longint'($signed(r.pos_x));
        qy = longint'($signed(r.pos_y));
        qz = longint'($signed(r.pos_z));
        if (r.opcode != tnpr_pkg::OP_UNUSED && r.item_kind == tnpr_pkg::KIND_NONE)
        begin
            res.status = tnpr_pkg::STS_KIND_NONE;
        end
        else if (r.opcode == tnpr_pkg::OP_REGISTER)
        begin
            for (int i = tnpr_pkg::MAX_ENTRIES - 1; i >= 0; i--)
                if (!table_live[i])
                    free_idx = i;
            if (free_idx < 0)
            begin
                res.status = tnpr_pkg::STS_FULL;
            end
            else
            begin
                table_live[free_idx] = 1'b1;
                table_kind[free_idx] = r.item_kind;
                table_id[free_idx]   = r.item_id;
                table_x[free_idx]    = qx;
                table_y[free_idx]    = qy;
                table_z[free_idx]    = qz;
            end
        end
        else if (r.opcode == tnpr_pkg::OP_UNREGISTER)
        begin
            for (int i = 0; i < tnpr_pkg::MAX_ENTRIES; i++)
                if (table_live[i] && table_kind[i] == r.item_kind && table_id[i] == r.item_id)
                    table_live[i] = 1'b0;
        end
        else if (r.opcode == tnpr_pkg::OP_QUERY)
        begin
            // Strict less-than: the lowest slot keeps a tie
            for (int i = 0; i < tnpr_pkg::MAX_ENTRIES; i++)
            begin
                if (table_live[i] && table_kind[i] == r.item_kind)
                begin
                    dx      = table_x[i] - qx;
                    dy      = table_y[i] - qy;
                    dz      = table_z[i] - qz;
                    dist_sq = dx * dx + dy * dy + dz * dz;
                    if (!found || dist_sq < best)
                    begin
                        found          = 1'b1;
                        best           = dist_sq;
                        res.nearest_id = table_id[i];
                    end
                end
            end
            if (found)
                res.nearest_dist_sq = best[tnpr_pkg::DIST_W-1:0];
            else
                res.status = tnpr_pkg::STS_NO_MATCH;
        end
        return res;
    endfunction

    function automatic stim_row_t mk_row(input tnpr_pkg::opcode_t op,
                                         input logic [tnpr_pkg::ID_W-1:0] id,
                                         input logic [tnpr_pkg::KIND_W-1:0] kind,
                                         input logic signed [tnpr_pkg::COORD_W-1:0] x,
                                         input logic signed [tnpr_pkg::COORD_W-1:0] y,
                                         input logic signed [tnpr_pkg::COORD_W-1:0] z,
                                         input bit pinned, input tnpr_pkg::status_t st,
                                         input logic [tnpr_pkg::ID_W-1:0] near_id);
        stim_row_t row;
        row.stim.opcode     = op;
        row.stim.item_id    = id;
        row.stim.item_kind  = kind;
        row.stim.pos_x      = x;
        row.stim.pos_y      = y;
        row.stim.pos_z      = z;
        row.pinned          = pinned;
        row.pinned_rsp      = '0;
        row.pinned_rsp.status     = st;
        row.pinned_rsp.nearest_id = near_id;
        return row;
    endfunction

    // Mostly small coordinates so that ties and near misses are common
    function automatic logic signed [tnpr_pkg::COORD_W-1:0] rand_coord();
        int pick;
        int v;
        pick = $urandom_range(99);
        if (pick < 25)
            return tnpr_pkg::COORD_W'($urandom());
        if (pick < 75)
        begin
            v = int'($urandom_range(127)) - 64;
            return v[tnpr_pkg::COORD_W-1:0];
        end
        case ($urandom_range(2))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            default: return '0;
        endcase
    endfunction

    // A few kinds carry most of the traffic so queries find entries
    function automatic logic [tnpr_pkg::KIND_W-1:0] rand_kind();
        int pick;
        pick = $urandom_range(99);
        if (pick < 3)
            return tnpr_pkg::KIND_NONE;
        if (pick < 63)
            return tnpr_pkg::KIND_W'($urandom_range(1, 3));
        return tnpr_pkg::KIND_W'($urandom_range(1, 15));
    endfunction

    function automatic tnpr_pkg::req_t make_random_item(input traffic_mix_t mix);
        tnpr_pkg::req_t r;
        int             pick;
        int             live_slots [$];
        int             reg_pct, unreg_pct, query_pct;
        case (mix)
            MIX_FILL:  begin reg_pct = 80; unreg_pct = 3;  query_pct = 15; end
            MIX_DRAIN: begin reg_pct = 10; unreg_pct = 50; query_pct = 38; end
            default:   begin reg_pct = 35; unreg_pct = 20; query_pct = 40; end
        endcase
        r.item_id   = ($urandom_range(1)) ? tnpr_pkg::ID_W'($urandom_range(7))
                                          : tnpr_pkg::ID_W'($urandom());
        r.item_kind = rand_kind();
        r.pos_x     = rand_coord();
        r.pos_y     = rand_coord();
        r.pos_z     = rand_coord();
        pick = $urandom_range(99);
        if (pick < reg_pct)
        begin
            r.opcode = tnpr_pkg::OP_REGISTER;
        end
        else if (pick < reg_pct + unreg_pct)
        begin
            r.opcode = tnpr_pkg::OP_UNREGISTER;
            // Aim most removals at a live entry
            for (int i = 0; i < tnpr_pkg::MAX_ENTRIES; i++)
                if (table_live[i])
                    live_slots.push_back(i);
            if (live_slots.size() != 0 && $urandom_range(99) < 75)
            begin
                pick        = live_slots[$urandom_range(live_slots.size() - 1)];
                r.item_id   = table_id[pick];
                r.item_kind = table_kind[pick];
            end
        end
        else if (pick < reg_pct + unreg_pct + query_pct)
        begin
            r.opcode = tnpr_pkg::OP_QUERY;
        end
        else
        begin
            r.opcode = tnpr_pkg::OP_UNUSED;
        end
        return r;
    endfunction

    // Present one item, hold it until accepted, then log what it must produce
    task automatic issue_item(input tnpr_pkg::req_t item, input bit pinned,
                              input tnpr_pkg::rsp_t pinned_rsp);
        tnpr_pkg::rsp_t predicted;
        req_valid <= 1'b1;
        req       <= item;
        do @(posedge clk); while (req_stall);
        predicted = registry_predict(item);
        expected_results.push_back(pinned ? pinned_rsp : predicted);
    endtask

    // Drop valid for a random stretch now and then
    task automatic maybe_idle();
        if (!steady_flow && $urandom_range(99) < 8)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 80)) @(posedge clk);
        end
    endtask

    function automatic void field_check(input string field, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            fail_count++;
        end
    endfunction

    // Result side: compare each accepted result with the oldest expectation,
    // then pick the stall level for the next cycle
    always @(posedge clk)
    begin
        tnpr_pkg::rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %0h", $time, rsp);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                field_check("status", want.status, rsp.status);
                field_check("nearest_id", want.nearest_id, rsp.nearest_id);
                field_check("nearest_dist_sq", want.nearest_dist_sq, rsp.nearest_dist_sq);
            end
        end
        rsp_stall <= !steady_flow && ($urandom_range(99) < 6);
    end

    // Directed items: empty table, kind none on every opcode, the unused opcode,
    // coordinate extremes, maximum distance, ties, duplicates and their removal
    initial
    begin
        directed_rows[0]  = mk_row(tnpr_pkg::OP_QUERY, 16'h0000, 4'd5, 0, 0, 0,
                                   1'b1, tnpr_pkg::STS_NO_MATCH, 0);
        directed_rows[1]  = mk_row(tnpr_pkg::OP_UNREGISTER, 16'h0001, 4'd5, 0, 0, 0,
                                   1'b1, tnpr_pkg::STS_OK, 0);
        directed_rows[2]  = mk_row(tnpr_pkg::OP_REGISTER, 16'hFFFF, tnpr_pkg::KIND_NONE,
                                   COORD_MAX, COORD_MIN, COORD_MAX,
                                   1'b1, tnpr_pkg::STS_KIND_NONE, 0);
        directed_rows[3]  = mk_row(tnpr_pkg::OP_UNREGISTER, 16'hFFFF, tnpr_pkg::KIND_NONE,
                                   0, 0, 0, 1'b1, tnpr_pkg::STS_KIND_NONE, 0);
        directed_rows[4]  = mk_row(tnpr_pkg::OP_QUERY, 16'h0000, tnpr_pkg::KIND_NONE,
                                   0, 0, 0, 1'b1, tnpr_pkg::STS_KIND_NONE, 0);
        directed_rows[5]  = mk_row(tnpr_pkg::OP_UNUSED, 16'hFFFF, tnpr_pkg::KIND_NONE,
                                   -1, -1, -1, 1'b1, tnpr_pkg::STS_OK, 0);
        directed_rows[6]  = mk_row(tnpr_pkg::OP_UNUSED, 16'hA5A5, 4'd9, COORD_MIN, 0, COORD_MAX,
                                   1'b1, tnpr_pkg::STS_OK, 0);
        directed_rows[7]  = mk_row(tnpr_pkg::OP_REGISTER, 16'hFFFF, 4'hF,
                                   COORD_MAX, COORD_MAX, COORD_MAX,
                                   1'b1, tnpr_pkg::STS_OK, 0);
        directed_rows[8]  = mk_row(tnpr_pkg::OP_REGISTER, 16'h0000, 4'hF,
                                   COORD_MIN, COORD_MIN, COORD_MIN,
                                   1'b1, tnpr_pkg::STS_OK, 0);
        directed_rows[9]  = mk_row(tnpr_pkg::OP_QUERY, 16'h0000, 4'hF,
                                   COORD_MIN, COORD_MIN, COORD_MIN,
                                   1'b1, tnpr_pkg::STS_OK, 16'h0000);
        directed_rows[10] = mk_row(tnpr_pkg::OP_QUERY, 16'h0000, 4'hF,
                                   COORD_MAX, COORD_MAX, COORD_MAX,
                                   1'b1, tnpr_pkg::STS_OK, 16'hFFFF);
        directed_rows[11] = mk_row(tnpr_pkg::OP_REGISTER, 16'h1234, 4'd1,
                                   COORD_MIN, COORD_MIN, COORD_MIN,
                                   1'b1, tnpr_pkg::STS_OK, 0);
        directed_rows[12] = mk_row(tnpr_pkg::OP_QUERY, 16'h0000, 4'd1,
                                   COORD_MAX, COORD_MAX, COORD_MAX,
                                   1'b0, tnpr_pkg::STS_OK, 0);
        directed_rows[13] = mk_row(tnpr_pkg::OP_REGISTER, 16'h0007, 4'd2, 10, 0, 0,
                                   1'b1, tnpr_pkg::STS_OK, 0);
        directed_rows[14] = mk_row(tnpr_pkg::OP_REGISTER, 16'h0008, 4'd2, -10, 0, 0,
                                   1'b1, tnpr_pkg::STS_OK, 0);
        directed_rows[15] = mk_row(tnpr_pkg::OP_QUERY, 16'h0000, 4'd2, 0, 0, 0,
                                   1'b0, tnpr_pkg::STS_OK, 0);
        directed_rows[16] = mk_row(tnpr_pkg::OP_REGISTER, 16'h0007, 4'd2, 100, 100, 100,
                                   1'b1, tnpr_pkg::STS_OK, 0);
        directed_rows[17] = mk_row(tnpr_pkg::OP_UNREGISTER, 16'h0007, 4'd3, 0, 0, 0,
                                   1'b1, tnpr_pkg::STS_OK, 0);
        directed_rows[18] = mk_row(tnpr_pkg::OP_QUERY, 16'h0000, 4'd2, 100, 100, 100,
                                   1'b0, tnpr_pkg::STS_OK, 0);
        directed_rows[19] = mk_row(tnpr_pkg::OP_UNREGISTER, 16'h0007, 4'd2, 0, 0, 0,
                                   1'b1, tnpr_pkg::STS_OK, 0);
        directed_rows[20] = mk_row(tnpr_pkg::OP_QUERY, 16'h0000, 4'd2, 100, 100, 100,
                                   1'b0, tnpr_pkg::STS_OK, 0);
        directed_rows[21] = mk_row(tnpr_pkg::OP_REGISTER, 16'h0009, 4'd2, 0, 0, 0,
                                   1'b0, tnpr_pkg::STS_OK, 0);
        directed_rows[22] = mk_row(tnpr_pkg::OP_UNREGISTER, 16'hFFFF, 4'hF, 0, 0, 0,
                                   1'b1, tnpr_pkg::STS_OK, 0);
        directed_rows[23] = mk_row(tnpr_pkg::OP_UNREGISTER, 16'h0000, 4'hF, 0, 0, 0,
                                   1'b1, tnpr_pkg::STS_OK, 0);
        directed_rows[24] = mk_row(tnpr_pkg::OP_UNREGISTER, 16'h1234, 4'd1, 0, 0, 0,
                                   1'b1, tnpr_pkg::STS_OK, 0);
    end

    // Main stimulus
    initial
    begin
        traffic_mix_t mix;
        int           run_left;
        int           sent;
        for (int i = 0; i < tnpr_pkg::MAX_ENTRIES; i++)
            table_live[i] = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            issue_item(directed_rows[i].stim, directed_rows[i].pinned,
                       directed_rows[i].pinned_rsp);
            maybe_idle();
        end

        // Open with a long fill run so the table reaches full early, then
        // switch between runs of random length and mix
        mix      = MIX_FILL;
        run_left = 110;
        sent     = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (run_left == 0)
            begin
                mix      = traffic_mix_t'($urandom_range(2));
                run_left = $urandom_range(30, 120);
            end
            steady_flow = (sent >= STEADY_FIRST) && (sent < STEADY_LAST);
            issue_item(make_random_item(mix), 1'b0, '0);
            run_left--;
            sent++;
            maybe_idle();
        end
        req_valid   <= 1'b0;
        steady_flow = 1'b0;

        // Wait out every pending result, then give the block time to misbehave
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("PASS typed_nearest_point_registry_top");
        else
            $display("FAIL typed_nearest_point_registry_top");
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial
    begin
        #10_000_000;
        $display("FAIL typed_nearest_point_registry_top");
        $finish;
    end

endmodule
